/* design/s2x_pkg.sv */
// ----------------------------------------------------------------------------
// Scale2x upscaler package
// Shared constants, types and dimension helpers for the Scale2x stream block.
// ----------------------------------------------------------------------------
package s2x_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT) + 1;
  localparam int DIM_W     = 11;
  localparam int PIX_W     = 32;
  localparam int OUT_POS_W = 10;

  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 1024;

  typedef logic [PIX_W-1:0]     pixel_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [COL_W:0]       span_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [OUT_POS_W-1:0] pos_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic   rd_en;
    col_t   rd_addr0;
    col_t   rd_addr1;
    logic   wr_en_a;
    logic   wr_en_b;
    col_t   wr_addr;
  } bank_req_t;

  typedef struct packed {
    logic   bank_sel;
    logic   b_ok;
    logic   f_ok;
    pixel_t d;
    pixel_t h;
    pos_t   col;
    pos_t   row;
    logic   last;
  } tap_t;

  function automatic span_t eff_width(dim_t v);
    span_t r;
    if (v == '0) begin
      r = span_t'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      r = span_t'(MAX_WIDTH);
    end else begin
      r = span_t'(v);
    end
    return r;
  endfunction

  function automatic row_t eff_height(dim_t v);
    row_t r;
    if (v == '0) begin
      r = row_t'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      r = row_t'(MAX_HEIGHT);
    end else begin
      r = row_t'(v);
    end
    return r;
  endfunction

endpackage

/* design/scale2x_pixel_upscaler.sv */
// ----------------------------------------------------------------------------
// Scale2x pixel upscaler
// Doubles a raster ARGB image by the Scale2x edge rule, one 2x2 block per source pixel.
// ----------------------------------------------------------------------------
// The block accepts one item per clock and keeps that rate indefinitely while
// the output side takes results. A source pixel's 2x2 block is presented on
// the output after the pixel below it is accepted: the row banks are read
// into registers at the accepting edge, and the corner rule then fills the
// output register once it is free. Two row banks of 1024 pixels each hold the
// centre row and the row above it; each reads two columns and writes one per
// clock. After the last source row, one flush item per column emits the bottom
// row, and frame_last marks the final block. The size registers are always
// ready and should be written only while no item is in flight.
module scale2x_pixel_upscaler (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  s2x_pkg::dim_t          cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   op,
  input  s2x_pkg::pixel_t        pixel,
  output logic                   out_valid,
  input  logic                   out_ready,
  output s2x_pkg::pixel_t        top_left,
  output s2x_pkg::pixel_t        top_right,
  output s2x_pkg::pixel_t        bottom_left,
  output s2x_pkg::pixel_t        bottom_right,
  output s2x_pkg::pos_t          src_col,
  output s2x_pkg::pos_t          src_row,
  output logic                   frame_last
);

  logic               take;
  logic               emit;
  s2x_pkg::tap_t      tap;
  s2x_pkg::bank_req_t req;
  s2x_pkg::pixel_t    e_prev;
  s2x_pkg::pixel_t    a_rd0;
  s2x_pkg::pixel_t    a_rd1;
  s2x_pkg::pixel_t    b_rd0;
  s2x_pkg::pixel_t    b_rd1;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;

  s2x_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_take  (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .op        (op),
    .pixel     (pixel),
    .e_prev    (e_prev),
    .emit      (emit),
    .tap       (tap),
    .req       (req)
  );

  s2x_row_bank u_bank_a (
    .clk      (clk),
    .rd_en    (req.rd_en),
    .rd_addr0 (req.rd_addr0),
    .rd_addr1 (req.rd_addr1),
    .wr_en    (req.wr_en_a),
    .wr_addr  (req.wr_addr),
    .wr_data  (pixel),
    .rd_data0 (a_rd0),
    .rd_data1 (a_rd1)
  );

  s2x_row_bank u_bank_b (
    .clk      (clk),
    .rd_en    (req.rd_en),
    .rd_addr0 (req.rd_addr0),
    .rd_addr1 (req.rd_addr1),
    .wr_en    (req.wr_en_b),
    .wr_addr  (req.wr_addr),
    .wr_data  (pixel),
    .rd_data0 (b_rd0),
    .rd_data1 (b_rd1)
  );

  s2x_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .emit         (emit),
    .tap          (tap),
    .a_rd0        (a_rd0),
    .a_rd1        (a_rd1),
    .b_rd0        (b_rd0),
    .b_rd1        (b_rd1),
    .out_ready    (out_ready),
    .in_ready     (in_ready),
    .e_prev       (e_prev),
    .out_valid    (out_valid),
    .top_left     (top_left),
    .top_right    (top_right),
    .bottom_left  (bottom_left),
    .bottom_right (bottom_right),
    .src_col      (src_col),
    .src_row      (src_row),
    .frame_last   (frame_last)
  );

endmodule

/* design/s2x_row_bank.sv */
// ----------------------------------------------------------------------------
// Scale2x row bank
// One source row of pixels with two registered read ports and one write port.
// ----------------------------------------------------------------------------
module s2x_row_bank (
  input  logic            clk,
  input  logic            rd_en,
  input  s2x_pkg::col_t   rd_addr0,
  input  s2x_pkg::col_t   rd_addr1,
  input  logic            wr_en,
  input  s2x_pkg::col_t   wr_addr,
  input  s2x_pkg::pixel_t wr_data,
  output s2x_pkg::pixel_t rd_data0,
  output s2x_pkg::pixel_t rd_data1
);

  s2x_pkg::pixel_t mem [s2x_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

/* design/s2x_seq.sv */
// ----------------------------------------------------------------------------
// Scale2x sequencer
// Holds the image size registers and the raster position, and issues the row
// bank accesses and the item tap for each accepted item that fits the phase.
// ----------------------------------------------------------------------------
module s2x_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_take,
  input  logic               cfg_index,
  input  s2x_pkg::dim_t      cfg_data,
  input  logic               take,
  input  logic               op,
  input  s2x_pkg::pixel_t    pixel,
  input  s2x_pkg::pixel_t    e_prev,
  output logic               emit,
  output s2x_pkg::tap_t      tap,
  output s2x_pkg::bank_req_t req
);

  s2x_pkg::dim_t  image_width;
  s2x_pkg::dim_t  image_height;
  s2x_pkg::col_t  in_col;
  s2x_pkg::row_t  in_row;
  s2x_pkg::col_t  flush_col;
  logic           bank_select;
  logic           left_live;

  s2x_pkg::span_t w;
  s2x_pkg::row_t  h;
  logic           in_phase;
  s2x_pkg::col_t  col_cur;
  s2x_pkg::col_t  x;
  s2x_pkg::span_t x_next;
  s2x_pkg::span_t w_m1;
  logic           row_end;
  logic           work;
  logic           writes;
  s2x_pkg::row_t  row_m1;

  always_comb begin
    w        = s2x_pkg::eff_width(image_width);
    h        = s2x_pkg::eff_height(image_height);
    w_m1     = w - s2x_pkg::span_t'(1);
    in_phase = in_row < h;
    col_cur  = in_phase ? in_col : flush_col;
    x        = ({1'b0, col_cur} < w) ? col_cur : w_m1[s2x_pkg::COL_W-1:0];
    x_next   = {1'b0, x} + s2x_pkg::span_t'(1);
    row_end  = x_next >= w;
    row_m1   = in_row - s2x_pkg::row_t'(1);
    if (in_phase) begin
      work = take && (op == s2x_pkg::OP_PIXEL);
    end else begin
      work = take && (op == s2x_pkg::OP_FLUSH);
    end
    emit   = work && (!in_phase || (in_row != '0));
    writes = work && in_phase;
  end

  always_comb begin
    req.rd_en    = emit;
    req.rd_addr0 = x;
    req.rd_addr1 = x_next[s2x_pkg::COL_W-1:0];
    req.wr_en_a  = writes && bank_select;
    req.wr_en_b  = writes && !bank_select;
    req.wr_addr  = x;
  end

  always_comb begin
    tap.bank_sel = bank_select;
    tap.b_ok     = in_row >= s2x_pkg::row_t'(2);
    tap.f_ok     = !row_end;
    tap.d        = left_live ? e_prev : '0;
    tap.h        = in_phase ? pixel : '0;
    tap.col      = s2x_pkg::pos_t'(x);
    tap.row      = s2x_pkg::pos_t'(row_m1);
    tap.last     = !in_phase && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= s2x_pkg::dim_t'(s2x_pkg::WIDTH_RESET);
      image_height <= s2x_pkg::dim_t'(s2x_pkg::HEIGHT_RESET);
    end else if (cfg_take) begin
      case (cfg_index)
        s2x_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        s2x_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col      <= '0;
      in_row      <= '0;
      flush_col   <= '0;
      bank_select <= 1'b0;
      left_live   <= 1'b0;
    end else if (work) begin
      if (in_phase) begin
        if (row_end) begin
          in_col      <= '0;
          in_row      <= in_row + s2x_pkg::row_t'(1);
          bank_select <= !bank_select;
          left_live   <= 1'b0;
        end else begin
          in_col <= x_next[s2x_pkg::COL_W-1:0];
          if (emit) begin
            left_live <= 1'b1;
          end
        end
      end else begin
        if (row_end) begin
          in_row    <= '0;
          in_col    <= '0;
          flush_col <= '0;
          left_live <= 1'b0;
        end else begin
          flush_col <= x_next[s2x_pkg::COL_W-1:0];
          left_live <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/s2x_blend.sv */
// ----------------------------------------------------------------------------
// Scale2x blend stage
// Pairs the item tap with the row bank read data, applies the Scale2x corner
// rule and holds the finished block in the output register.
// ----------------------------------------------------------------------------
module s2x_blend (
  input  logic            clk,
  input  logic            rst,
  input  logic            emit,
  input  s2x_pkg::tap_t   tap,
  input  s2x_pkg::pixel_t a_rd0,
  input  s2x_pkg::pixel_t a_rd1,
  input  s2x_pkg::pixel_t b_rd0,
  input  s2x_pkg::pixel_t b_rd1,
  input  logic            out_ready,
  output logic            in_ready,
  output s2x_pkg::pixel_t e_prev,
  output logic            out_valid,
  output s2x_pkg::pixel_t top_left,
  output s2x_pkg::pixel_t top_right,
  output s2x_pkg::pixel_t bottom_left,
  output s2x_pkg::pixel_t bottom_right,
  output s2x_pkg::pos_t   src_col,
  output s2x_pkg::pos_t   src_row,
  output logic            frame_last
);

  logic            stage_valid;
  s2x_pkg::tap_t   stage;
  logic            advance;
  s2x_pkg::pixel_t pb;
  s2x_pkg::pixel_t pd;
  s2x_pkg::pixel_t pe;
  s2x_pkg::pixel_t pf;
  s2x_pkg::pixel_t ph;
  s2x_pkg::pixel_t e0;
  s2x_pkg::pixel_t e1;
  s2x_pkg::pixel_t e2;
  s2x_pkg::pixel_t e3;

  always_comb begin
    advance  = stage_valid && (!out_valid || out_ready);
    in_ready = !stage_valid || !out_valid || out_ready;
    pe       = stage.bank_sel ? b_rd0 : a_rd0;
    e_prev   = pe;
    pf       = stage.f_ok ? (stage.bank_sel ? b_rd1 : a_rd1) : '0;
    pb       = stage.b_ok ? (stage.bank_sel ? a_rd0 : b_rd0) : '0;
    pd       = stage.d;
    ph       = stage.h;
    e0 = (pd == pb && pb != pf && pd != ph) ? pd : pe;
    e1 = (pb == pf && pb != pd && pf != ph) ? pf : pe;
    e2 = (pd == ph && pd != pb && ph != pf) ? pd : pe;
    e3 = (ph == pf && pd != ph && pb != pf) ? pf : pe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (emit) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      stage <= tap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      top_left     <= e0;
      top_right    <= e1;
      bottom_left  <= e2;
      bottom_right <= e3;
      src_col      <= stage.col;
      src_row      <= stage.row;
      frame_last   <= stage.last;
    end
  end

endmodule

/* tb/sv/scale2x_block_checker.sv */
// ----------------------------------------------------------------------------
// Scale2x block checker
// Watches the size, input and output channels of the upscaler, keeps its own
// model of the row buffers and counters, works out the 2x2 block that each
// accepted item produces and compares every delivered block field by field.
// ----------------------------------------------------------------------------
module scale2x_block_checker
  import s2x_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_valid,
  input  logic   cfg_ready,
  input  logic   cfg_index,
  input  dim_t   cfg_data,
  input  logic   in_valid,
  input  logic   in_ready,
  input  logic   op,
  input  pixel_t pixel,
  input  logic   out_valid,
  input  logic   out_ready,
  input  pixel_t top_left,
  input  pixel_t top_right,
  input  pixel_t bottom_left,
  input  pixel_t bottom_right,
  input  pos_t   src_col,
  input  pos_t   src_row,
  input  logic   frame_last,
  output int     errors,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pixel_t tl;
    pixel_t tr;
    pixel_t bl;
    pixel_t br;
    pos_t   col;
    pos_t   row;
    logic   last;
  } block_t;

  block_t      blocks_due[$];
  pixel_t      rows [2][MAX_WIDTH];
  dim_t        width_reg;
  dim_t        height_reg;
  int unsigned next_col;
  int unsigned next_row;
  int unsigned flush_pos;
  pixel_t      left_px;
  bit          center;

  function automatic int unsigned clamp_dim(dim_t v, int unsigned top);
    if (v == '0) return 1;
    return (v > top) ? top : v;
  endfunction

  function automatic block_t corner_rule(pixel_t b, pixel_t d, pixel_t e, pixel_t f,
                                         pixel_t h, int unsigned x, int unsigned y,
                                         logic last);
    block_t r;
    r.tl   = (d == b && b != f && d != h) ? d : e;
    r.tr   = (b == f && b != d && f != h) ? f : e;
    r.bl   = (d == h && d != b && h != f) ? d : e;
    r.br   = (h == f && d != h && b != f) ? f : e;
    r.col  = pos_t'(x);
    r.row  = pos_t'(y);
    r.last = last;
    return r;
  endfunction

  task automatic advance_on_item(input op_t o, input pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    pixel_t      above;
    pixel_t      mid;
    pixel_t      right;
    logic        is_last;
    bit          other;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    other = center ^ 1'b1;
    if (next_row < h) begin
      if (o == OP_FLUSH) return;
      x = (next_col < w) ? next_col : w - 1;
      if (next_row > 0) begin
        above = (next_row >= 2) ? rows[other][x] : '0;
        mid   = rows[center][x];
        right = (x + 1 < w) ? rows[center][x + 1] : '0;
        blocks_due.push_back(corner_rule(above, left_px, mid, right, px, x,
                                         next_row - 1, 1'b0));
        left_px = mid;
      end
      rows[other][x] = px;
      if (x + 1 >= w) begin
        next_col = 0;
        next_row++;
        center  = other;
        left_px = '0;
      end else begin
        next_col = x + 1;
      end
    end else begin
      if (o == OP_PIXEL) return;
      x       = (flush_pos < w) ? flush_pos : w - 1;
      above   = (next_row >= 2) ? rows[other][x] : '0;
      mid     = rows[center][x];
      right   = (x + 1 < w) ? rows[center][x + 1] : '0;
      is_last = (x + 1 >= w);
      blocks_due.push_back(corner_rule(above, left_px, mid, right, '0, x,
                                       next_row - 1, is_last));
      if (is_last) begin
        next_row  = 0;
        next_col  = 0;
        flush_pos = 0;
        left_px   = '0;
      end else begin
        left_px   = mid;
        flush_pos = x + 1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic compare_block();
    block_t want;
    if (blocks_due.size() == 0) begin
      $error("block for column %0d row %0d arrived with none expected", src_col, src_row);
      errors++;
      return;
    end
    want = blocks_due.pop_front();
    check_field("top_left", want.tl, top_left);
    check_field("top_right", want.tr, top_right);
    check_field("bottom_left", want.bl, bottom_left);
    check_field("bottom_right", want.br, bottom_right);
    check_field("src_col", want.col, src_col);
    check_field("src_row", want.row, src_row);
    check_field("frame_last", want.last, frame_last);
  endtask

  // Inputs change only at rising edges, so the values seen at the falling edge
  // are exactly those that the next rising edge takes.
  always @(negedge clk) begin
    if (rst) begin
      blocks_due.delete();
      width_reg  = dim_t'(WIDTH_RESET);
      height_reg = dim_t'(HEIGHT_RESET);
      next_col   = 0;
      next_row   = 0;
      flush_pos  = 0;
      left_px    = '0;
      center     = 1'b0;
      errors     = 0;
    end else begin
      if (out_valid && out_ready) compare_block();
      if (cfg_valid && cfg_ready) begin
        if (cfg_reg_t'(cfg_index) == REG_IMAGE_WIDTH) begin
          width_reg = cfg_data;
        end else begin
          height_reg = cfg_data;
        end
      end
      if (in_valid && in_ready) advance_on_item(op_t'(op), pixel);
    end
    pending = blocks_due.size();
  end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Scale2x upscaler testbench
// Writes image sizes between frames and mid-frame, streams raster frames and
// flush items with random gaps and output stalls, reports the checker verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import s2x_pkg::*;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic   cfg_index = 1'b0;
  dim_t   cfg_data = '0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   op = 1'b0;
  pixel_t pixel = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  pixel_t top_left;
  pixel_t top_right;
  pixel_t bottom_left;
  pixel_t bottom_right;
  pos_t   src_col;
  pos_t   src_row;
  logic   frame_last;
  int     errors;
  int     pending;

  logic   in_take = 1'b0;
  logic   cfg_take = 1'b0;
  bit     calm = 1'b0;
  int     stall_left = 0;
  int     fed = 0;
  pixel_t shade [4];

  scale2x_pixel_upscaler uut (.*);
  scale2x_block_checker checker_i (.*);

  always #4 clk = ~clk;

  always @(negedge clk) begin
    in_take  <= in_valid && in_ready;
    cfg_take <= cfg_valid && cfg_ready;
  end

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic pixel_t pick_pixel();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return shade[$urandom_range(0, 3)];
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_pause();
    end
  end

  task automatic send_item(input op_t o, input pixel_t p);
    int gap;
    gap = calm ? 0 : pick_pause();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    pixel    <= p;
    do @(posedge clk); while (!in_take);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input dim_t val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_take);
    cfg_valid <= 1'b0;
  endtask

  task automatic new_palette();
    for (int i = 0; i < 4; i++) shade[i] = $urandom();
    if ($urandom_range(0, 1)) shade[0] = '0;
    if ($urandom_range(0, 1)) shade[1] = '1;
  endtask

  task automatic send_frame(input int w, input int h, input bit noisy);
    new_palette();
    for (int n = 0; n < w * h; n++) begin
      if (noisy && $urandom_range(0, 39) == 0) send_item(OP_FLUSH, $urandom());
      if (noisy && $urandom_range(0, 199) == 0) settle();
      send_item(OP_PIXEL, pick_pixel());
      fed++;
    end
    for (int n = 0; n < w; n++) begin
      if (noisy && $urandom_range(0, 39) == 0) send_item(OP_PIXEL, $urandom());
      send_item(OP_FLUSH, $urandom());
      fed++;
    end
  endtask

  initial begin
    pixel_t grid [9];
    int     w;
    int     h;
    int     r;
    grid = '{32'h0, 32'hFFFF_FFFF, 32'h0,
             32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
             32'h0, 32'h0, 32'hFFFF_FFFF};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // A 3x3 black and white grid with a stray flush before the frame and a stray
    // pixel once the frame is complete.
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    send_item(OP_FLUSH, 32'hFFFF_FFFF);
    for (int i = 0; i < 9; i++) send_item(OP_PIXEL, grid[i]);
    send_item(OP_PIXEL, 32'h1234_5678);
    for (int i = 0; i < 3; i++) send_item(OP_FLUSH, '0);

    // Sizes shrunk in the middle of a frame: the width puts the last pixel of
    // row one in column one, then the height sends the frame straight to its flush.
    write_reg(REG_IMAGE_WIDTH, 4);
    write_reg(REG_IMAGE_HEIGHT, 4);
    new_palette();
    for (int i = 0; i < 7; i++) send_item(OP_PIXEL, pick_pixel());
    write_reg(REG_IMAGE_WIDTH, 2);
    send_item(OP_PIXEL, pick_pixel());
    write_reg(REG_IMAGE_HEIGHT, 2);
    for (int i = 0; i < 2; i++) send_item(OP_FLUSH, '0);

    // Largest and out-of-range sizes, streamed back to back.
    calm = 1'b1;
    write_reg(REG_IMAGE_WIDTH, 2047);
    write_reg(REG_IMAGE_HEIGHT, 0);
    send_frame(1024, 1, 1'b0);
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 1024);
    send_frame(1, 1024, 1'b0);
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 1500);
    send_frame(1, 1024, 1'b0);
    calm = 1'b0;

    fed = 0;
    while (fed < 1000) begin
      r = $urandom_range(0, 19);
      w = (r < 14) ? $urandom_range(1, 6) :
          (r < 19) ? $urandom_range(7, 24) : $urandom_range(25, 64);
      h = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      write_reg(REG_IMAGE_WIDTH, dim_t'((w == 1 && $urandom_range(0, 1)) ? 0 : w));
      write_reg(REG_IMAGE_HEIGHT, dim_t'((h == 1 && $urandom_range(0, 1)) ? 0 : h));
      calm = ($urandom_range(0, 4) == 0);
      send_frame(w, h, 1'b1);
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
